// ----- sv/i2cs_pkg.sv -----
// i2cs_pkg: types, codes and constants for the I2C master bit sequencer.
// No dependencies; imported by i2cs_step and i2c_master_bit_sequencer.
`default_nettype none

package i2cs_pkg;

   localparam int unsigned DELAY_W = 16;
   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned BCNT_W  = 4;

   localparam logic [DELAY_W-1:0] DELAY_TICKS_RESET = 16'd5;
   localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET   = 8'd250;
   localparam logic [BCNT_W-1:0]  BITS_PER_BYTE     = 4'd8;

   typedef enum logic [0:0] {
      CSR_DELAY_TICKS = 1'b0,
      CSR_ACK_LIMIT   = 1'b1
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE  = 3'd0,
      MODE_START = 3'd1,
      MODE_STOP  = 3'd2,
      MODE_WRITE = 3'd3,
      MODE_WAIT  = 3'd4,
      MODE_READ  = 3'd5
   } mode_type;

   typedef enum logic [5:0] {
      OP_IDLE  = 6'b000001,
      OP_START = 6'b000010,
      OP_STOP  = 6'b000100,
      OP_WRITE = 6'b001000,
      OP_WAIT  = 6'b010000,
      OP_READ  = 6'b100000
   } op_type;

   typedef enum logic [5:0] {
      PH_0 = 6'b000001,
      PH_1 = 6'b000010,
      PH_2 = 6'b000100,
      PH_3 = 6'b001000,
      PH_4 = 6'b010000,
      PH_5 = 6'b100000
   } phase_type;

   typedef struct packed {
      op_type              op;
      phase_type           phase;
      logic [BCNT_W-1:0]   bit_count;
      logic [BYTE_W-1:0]   shift_reg;
      logic [DELAY_W-1:0]  delay_count;
      logic [LIMIT_W-1:0]  ack_timer;
      logic                ack_choice;
      logic                scl;
      logic                sda;
      logic [BYTE_W-1:0]   rx;
      logic                err;
   } state_type;

   typedef struct packed {
      logic [DELAY_W-1:0] delay_ticks;
      logic [LIMIT_W-1:0] ack_limit;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] tx_byte;
      logic              send_ack;
      logic              sda_level;
   } item_type;

endpackage

`default_nettype wire

// ----- sv/i2cs_step.sv -----
// i2cs_step: next state of the sequencer for one tick.
// Depends on i2cs_pkg.
`default_nettype none

module i2cs_step
   import i2cs_pkg::*;
(
   input  var state_type cur,
   input  var item_type  item,
   input  var cfg_type   cfg,
   output state_type     nxt,
   output logic          done
);

   logic [DELAY_W-1:0] arm;
   logic [BCNT_W-1:0]  bit_inc;

   assign arm     = (cfg.delay_ticks == '0) ? DELAY_W'(1) : cfg.delay_ticks;
   assign bit_inc = cur.bit_count + BCNT_W'(1);

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      priority if (cur.op == OP_IDLE) begin
         unique case (mode_type'(item.mode))
            MODE_START: begin
               nxt.op          = OP_START;
               nxt.phase       = PH_1;
               nxt.sda         = 1'b0;
               nxt.scl         = 1'b1;
               nxt.delay_count = arm;
            end
            MODE_STOP: begin
               nxt.op          = OP_STOP;
               nxt.phase       = PH_1;
               nxt.scl         = 1'b0;
               nxt.sda         = 1'b1;
               nxt.delay_count = arm;
            end
            MODE_WRITE: begin
               nxt.op          = OP_WRITE;
               nxt.phase       = PH_1;
               nxt.scl         = 1'b0;
               nxt.bit_count   = '0;
               nxt.sda         = ~item.tx_byte[BYTE_W-1];
               nxt.shift_reg   = {item.tx_byte[BYTE_W-2:0], 1'b0};
               nxt.delay_count = arm;
            end
            MODE_WAIT: begin
               nxt.op          = OP_WAIT;
               nxt.phase       = PH_1;
               nxt.err         = 1'b0;
               nxt.sda         = 1'b0;
               nxt.delay_count = arm;
            end
            MODE_READ: begin
               nxt.op          = OP_READ;
               nxt.phase       = PH_1;
               nxt.sda         = 1'b0;
               nxt.scl         = 1'b0;
               nxt.shift_reg   = '0;
               nxt.bit_count   = '0;
               nxt.ack_choice  = item.send_ack;
               nxt.delay_count = arm;
            end
            default: ;
         endcase
      end else if (cur.op == OP_WAIT && cur.phase == PH_4) begin
         priority if (!item.sda_level) begin
            nxt.scl   = 1'b0;
            nxt.op    = OP_IDLE;
            nxt.phase = PH_0;
            done      = 1'b1;
         end else if (cur.ack_timer >= cfg.ack_limit) begin
            nxt.err         = 1'b1;
            nxt.op          = OP_STOP;
            nxt.phase       = PH_1;
            nxt.scl         = 1'b0;
            nxt.sda         = 1'b1;
            nxt.delay_count = arm;
         end else begin
            nxt.ack_timer = cur.ack_timer + LIMIT_W'(1);
         end
      end else if (cur.delay_count > DELAY_W'(1)) begin
         nxt.delay_count = cur.delay_count - DELAY_W'(1);
      end else begin
         nxt.delay_count = '0;
         unique case (cur.op)
            OP_START: begin
               if (cur.phase == PH_1) begin
                  nxt.sda         = 1'b1;
                  nxt.phase       = PH_2;
                  nxt.delay_count = arm;
               end else begin
                  nxt.scl   = 1'b0;
                  nxt.op    = OP_IDLE;
                  nxt.phase = PH_0;
                  done      = 1'b1;
               end
            end
            OP_STOP: begin
               priority if (cur.phase == PH_1) begin
                  nxt.scl         = 1'b1;
                  nxt.phase       = PH_2;
                  nxt.delay_count = arm;
               end else if (cur.phase == PH_2) begin
                  nxt.sda         = 1'b0;
                  nxt.phase       = PH_3;
                  nxt.delay_count = arm;
               end else begin
                  nxt.op    = OP_IDLE;
                  nxt.phase = PH_0;
                  done      = 1'b1;
               end
            end
            OP_WRITE: begin
               priority if (cur.phase == PH_1) begin
                  nxt.scl         = 1'b1;
                  nxt.phase       = PH_2;
                  nxt.delay_count = arm;
               end else if (cur.phase == PH_2) begin
                  nxt.scl         = 1'b0;
                  nxt.phase       = PH_3;
                  nxt.delay_count = arm;
               end else begin
                  nxt.bit_count = bit_inc;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     nxt.op    = OP_IDLE;
                     nxt.phase = PH_0;
                     done      = 1'b1;
                  end else begin
                     nxt.sda         = ~cur.shift_reg[BYTE_W-1];
                     nxt.shift_reg   = {cur.shift_reg[BYTE_W-2:0], 1'b0};
                     nxt.phase       = PH_1;
                     nxt.delay_count = arm;
                  end
               end
            end
            OP_WAIT: begin
               if (cur.phase == PH_3) begin
                  nxt.phase = PH_4;
               end else begin
                  nxt.scl         = 1'b1;
                  nxt.ack_timer   = '0;
                  nxt.phase       = PH_3;
                  nxt.delay_count = arm;
               end
            end
            OP_READ: begin
               priority if (cur.phase == PH_1) begin
                  nxt.scl         = 1'b1;
                  nxt.shift_reg   = {cur.shift_reg[BYTE_W-2:0], item.sda_level};
                  nxt.phase       = PH_3;
                  nxt.delay_count = arm;
               end else if (cur.phase == PH_2 || cur.phase == PH_3) begin
                  nxt.bit_count   = bit_inc;
                  nxt.scl         = 1'b0;
                  nxt.delay_count = arm;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     nxt.rx    = cur.shift_reg;
                     nxt.sda   = cur.ack_choice;
                     nxt.phase = PH_4;
                  end else begin
                     nxt.phase = PH_1;
                  end
               end else if (cur.phase == PH_4) begin
                  nxt.scl         = 1'b1;
                  nxt.phase       = PH_5;
                  nxt.delay_count = arm;
               end else begin
                  nxt.scl   = 1'b0;
                  nxt.op    = OP_IDLE;
                  nxt.phase = PH_0;
                  done      = 1'b1;
               end
            end
            default: begin
               nxt.op    = OP_IDLE;
               nxt.phase = PH_0;
               done      = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- sv/i2c_master_bit_sequencer.sv -----
// i2c_master_bit_sequencer: tick-paced I2C master pin sequencer, top level.
// Depends on i2cs_pkg and i2cs_step.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  mode, tx_byte, send_ack, sda_level
//   rsp_     out        rsp_valid/rsp_stall  scl, sda drive, busy, done, rx, error
//   csr_     in         csr_write_enable     csr_index, csr_wdata
//
// One tick is taken per clock cycle while rsp_ is not stalled; a taken tick is registered
// in the input register, and its result in the result register, from which it transfers.
// The state update sits between the two registers.
// reset clears the sequencer to idle with SCL high, SDA released, CSRs at their defaults.
// A stall on rsp_ holds the result register and stalls req_ once the input register fills.
`default_nettype none

module i2c_master_bit_sequencer
   import i2cs_pkg::*;
(
   input  var logic               clock,
   input  var logic               reset,
   input  var logic               req_valid,
   output logic                   req_stall,
   input  var logic [MODE_W-1:0]  req_mode,
   input  var logic [BYTE_W-1:0]  req_tx_byte,
   input  var logic               req_send_ack,
   input  var logic               req_sda_level,
   output logic                   rsp_valid,
   input  var logic               rsp_stall,
   output logic                   rsp_scl_level,
   output logic                   rsp_sda_drive_low,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic [BYTE_W-1:0]      rsp_rx_byte,
   output logic                   rsp_ack_error,
   input  var logic               csr_write_enable,
   input  var logic [0:0]         csr_index,
   input  var logic [DELAY_W-1:0] csr_wdata
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   item_type  item_ff;
   item_type  item_in;
   logic      item_valid_ff;
   logic      item_valid_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_err_ff;
   logic [BYTE_W-1:0] rsp_rx_ff;
   state_type step_nxt;
   logic      step_done;
   logic      req_take;
   logic      step_go;

   i2cs_step u_step (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg_ff),
      .nxt  (step_nxt),
      .done (step_done)
   );

   assign step_go   = item_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = item_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY_TICKS: cfg_in.delay_ticks = csr_wdata;
            CSR_ACK_LIMIT:   cfg_in.ack_limit   = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign item_in       = req_take ? item_type'{req_mode, req_tx_byte, req_send_ack,
                                                req_sda_level}
                                   : item_ff;
   assign item_valid_in = req_take | (item_valid_ff & ~step_go);
   assign state_in      = step_go ? step_nxt : state_ff;
   assign rsp_valid_in  = step_go | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{DELAY_TICKS_RESET, ACK_LIMIT_RESET};
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{op: OP_IDLE, phase: PH_0, scl: 1'b1, default: '0};
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (step_go) begin
         rsp_scl_ff  <= step_nxt.scl;
         rsp_sda_ff  <= step_nxt.sda;
         rsp_busy_ff <= (step_nxt.op != OP_IDLE);
         rsp_done_ff <= step_done;
         rsp_rx_ff   <= step_nxt.rx;
         rsp_err_ff  <= step_nxt.err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scl_level     = rsp_scl_ff;
   assign rsp_sda_drive_low = rsp_sda_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_rx_byte       = rsp_rx_ff;
   assign rsp_ack_error     = rsp_err_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_ff && rsp_busy_ff))
      else $error("done and busy reported together");

   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.op == OP_IDLE |-> state_ff.phase == PH_0)
      else $error("idle sequencer left a phase behind");

   a_idle_delay: assert property (@(posedge clock) disable iff (reset)
      state_ff.op == OP_IDLE |-> state_ff.delay_count == '0)
      else $error("idle sequencer holds a running delay");

   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_count <= BITS_PER_BYTE)
      else $error("bit counter ran past a byte");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step_go |=> rsp_valid_ff && rsp_busy_ff == (state_ff.op != OP_IDLE))
      else $error("result register out of step with sequencer state");

endmodule

`default_nettype wire

// ----- test/i2c_master_bit_sequencer_test.sv -----
// Self-checking testbench for i2c_master_bit_sequencer: random and directed ticks drive the
// pin sequencer through every command while a tick-level model predicts each result transfer.
// Depends on i2cs_pkg and the i2c_master_bit_sequencer RTL.
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_test;
   import i2cs_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

   typedef struct packed {
      mode_type            op;
      logic [3:0]          step;
      logic [BCNT_W-1:0]   bits_done;
      logic [BYTE_W-1:0]   shifter;
      logic [DELAY_W-1:0]  hold_left;
      logic [LIMIT_W-1:0]  poll_count;
      logic                ack_bit;
      logic                scl;
      logic                sda_low;
      logic [BYTE_W-1:0]   rx;
      logic                err;
   } seq_state_type;

   typedef struct packed {
      logic              scl;
      logic              sda_low;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] rx;
      logic              err;
   } pin_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode = '0;
   logic [BYTE_W-1:0]  req_tx_byte = '0;
   logic               req_send_ack = 1'b0;
   logic               req_sda_level = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_scl_level;
   logic               rsp_sda_drive_low;
   logic               rsp_busy_res;
   logic               rsp_done_res;
   logic [BYTE_W-1:0]  rsp_rx_byte;
   logic               rsp_ack_error;
   logic               csr_write_enable = 1'b0;
   logic [0:0]         csr_index = '0;
   logic [DELAY_W-1:0] csr_wdata = '0;

   cfg_type        cfg;
   seq_state_type  tick_model;
   seq_state_type  plan_state;
   int             plan_polls;
   int             plan_ack_after;
   item_type       pending_ticks[$];
   pin_result_type expected_pins[$];
   item_type       next_tick;
   item_type       taken;
   pin_result_type want;
   pin_result_type got;
   logic           req_taken = 1'b0;
   bit             gaps_on = 1'b1;
   int             req_gap = 0;
   int             stall_left = 0;
   int             faults = 0;

   i2c_master_bit_sequencer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_tx_byte       (req_tx_byte),
      .req_send_ack      (req_send_ack),
      .req_sda_level     (req_sda_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_scl_level     (rsp_scl_level),
      .rsp_sda_drive_low (rsp_sda_drive_low),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_done_res      (rsp_done_res),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_ack_error     (rsp_ack_error),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic seq_state_type seq_idle();
      seq_state_type s;
      s = '0;
      s.op = MODE_NONE;
      s.scl = 1'b1;
      return s;
   endfunction

   function automatic logic [DELAY_W-1:0] hold_len(input cfg_type c);
      return (c.delay_ticks == '0) ? 16'd1 : c.delay_ticks;
   endfunction

   function automatic void launch_stop(inout seq_state_type s, input cfg_type c);
      s.op = MODE_STOP;
      s.step = 4'd1;
      s.scl = 1'b0;
      s.sda_low = 1'b1;
      s.hold_left = hold_len(c);
   endfunction

   function automatic void shift_out(inout seq_state_type s);
      s.sda_low = ~s.shifter[7];
      s.shifter = {s.shifter[6:0], 1'b0};
   endfunction

   // one tick of the sequencer: state after the tick and its result
   function automatic void seq_tick(inout seq_state_type s, input cfg_type c,
                                    input item_type t, output pin_result_type r);
      logic fin;
      fin = 1'b0;
      if (s.op == MODE_NONE) begin
         if (t.mode >= MODE_START && t.mode <= MODE_READ) begin
            s.op = mode_type'(t.mode);
            s.step = 4'd1;
            s.hold_left = hold_len(c);
            case (s.op)
               MODE_START: begin
                  s.sda_low = 1'b0;
                  s.scl = 1'b1;
               end
               MODE_STOP: launch_stop(s, c);
               MODE_WRITE: begin
                  s.scl = 1'b0;
                  s.shifter = t.tx_byte;
                  s.bits_done = '0;
                  shift_out(s);
               end
               MODE_WAIT: begin
                  s.err = 1'b0;
                  s.sda_low = 1'b0;
               end
               default: begin
                  s.sda_low = 1'b0;
                  s.scl = 1'b0;
                  s.shifter = '0;
                  s.bits_done = '0;
                  s.ack_bit = t.send_ack;
               end
            endcase
         end
      end else if (s.op == MODE_WAIT && s.step == 4'd4) begin
         if (!t.sda_level) begin
            s.scl = 1'b0;
            fin = 1'b1;
         end else if (s.poll_count >= c.ack_limit) begin
            s.err = 1'b1;
            launch_stop(s, c);
         end else begin
            s.poll_count++;
         end
      end else if (s.hold_left > 16'd1) begin
         s.hold_left--;
      end else begin
         s.hold_left = '0;
         case (s.op)
            MODE_START: begin
               if (s.step == 4'd1) begin
                  s.sda_low = 1'b1;
                  s.step = 4'd2;
                  s.hold_left = hold_len(c);
               end else begin
                  s.scl = 1'b0;
                  fin = 1'b1;
               end
            end
            MODE_STOP: begin
               if (s.step == 4'd1) begin
                  s.scl = 1'b1;
                  s.step = 4'd2;
                  s.hold_left = hold_len(c);
               end else if (s.step == 4'd2) begin
                  s.sda_low = 1'b0;
                  s.step = 4'd3;
                  s.hold_left = hold_len(c);
               end else begin
                  fin = 1'b1;
               end
            end
            MODE_WRITE: begin
               if (s.step == 4'd1) begin
                  s.scl = 1'b1;
                  s.step = 4'd2;
                  s.hold_left = hold_len(c);
               end else if (s.step == 4'd2) begin
                  s.scl = 1'b0;
                  s.step = 4'd3;
                  s.hold_left = hold_len(c);
               end else begin
                  s.bits_done++;
                  if (s.bits_done >= BITS_PER_BYTE) begin
                     fin = 1'b1;
                  end else begin
                     shift_out(s);
                     s.step = 4'd1;
                     s.hold_left = hold_len(c);
                  end
               end
            end
            MODE_WAIT: begin
               if (s.step == 4'd3) begin
                  s.step = 4'd4;
               end else begin
                  s.scl = 1'b1;
                  s.poll_count = '0;
                  s.step = 4'd3;
                  s.hold_left = hold_len(c);
               end
            end
            MODE_READ: begin
               if (s.step == 4'd1) begin
                  s.scl = 1'b1;
                  s.shifter = {s.shifter[6:0], t.sda_level};
                  s.step = 4'd3;
                  s.hold_left = hold_len(c);
               end else if (s.step == 4'd3) begin
                  s.bits_done++;
                  s.scl = 1'b0;
                  if (s.bits_done >= BITS_PER_BYTE) begin
                     s.rx = s.shifter;
                     s.sda_low = s.ack_bit;
                     s.step = 4'd4;
                  end else begin
                     s.step = 4'd1;
                  end
                  s.hold_left = hold_len(c);
               end else if (s.step == 4'd4) begin
                  s.scl = 1'b1;
                  s.step = 4'd5;
                  s.hold_left = hold_len(c);
               end else begin
                  s.scl = 1'b0;
                  fin = 1'b1;
               end
            end
            default: fin = 1'b1;
         endcase
      end
      if (fin) begin
         s.op = MODE_NONE;
         s.step = '0;
      end
      r.scl = s.scl;
      r.sda_low = s.sda_low;
      r.busy = (s.op != MODE_NONE);
      r.done = fin;
      r.rx = s.rx;
      r.err = s.err;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(5, 40);
   endfunction

   function automatic int pick_ack_after();
      int lim;
      int r;
      lim = int'(cfg.ack_limit);
      r = $urandom_range(0, 99);
      if (r < 25) return 1000;
      else if (r < 45) return lim + $urandom_range(0, 1);
      else return $urandom_range(0, (lim < 12) ? lim : 12);
   endfunction

   task automatic plan_push(input item_type t);
      pin_result_type unused;
      seq_tick(plan_state, cfg, t, unused);
      pending_ticks.push_back(t);
   endtask

   // issue one command, then tick until the sequence completes
   task automatic queue_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] tx,
                                input logic ack, input int ack_after, input bit noisy);
      item_type t;
      plan_ack_after = ack_after;
      plan_polls = 0;
      t.mode = mode;
      t.tx_byte = tx;
      t.send_ack = ack;
      t.sda_level = 1'($urandom);
      plan_push(t);
      while (plan_state.op != MODE_NONE) begin
         t.mode = noisy ? 3'($urandom_range(0, 7)) : MODE_NONE;
         t.tx_byte = 8'($urandom);
         t.send_ack = 1'($urandom);
         if (plan_state.op == MODE_WAIT && plan_state.step == 4'd4) begin
            t.sda_level = (plan_polls < plan_ack_after);
            plan_polls++;
         end else begin
            t.sda_level = 1'($urandom);
         end
         plan_push(t);
      end
   endtask

   task automatic queue_random(input int n);
      int r;
      while (pending_ticks.size() < n) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            queue_command((r < 3) ? MODE_NONE : (r < 6) ? MODE_UNUSED_A : MODE_UNUSED_B,
                          8'($urandom), 1'($urandom), 0, 1'b0);
         else
            queue_command(3'($urandom_range(1, 5)), 8'($urandom), 1'($urandom),
                          pick_ack_after(), ($urandom_range(0, 3) == 0));
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [DELAY_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_DELAY_TICKS) cfg.delay_ticks = data;
      else cfg.ack_limit = data[LIMIT_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_ticks.size() != 0 || req_valid || expected_pins.size() != 0);
      repeat (4) @(posedge clock);
      #1;
   endtask

   task automatic compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
         faults++;
      end
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_ticks.size() != 0) begin
            next_tick = pending_ticks.pop_front();
            req_mode <= next_tick.mode;
            req_tx_byte <= next_tick.tx_byte;
            req_send_ack <= next_tick.send_ack;
            req_sda_level <= next_tick.sda_level;
            req_valid <= 1'b1;
            req_gap = gaps_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = gaps_on ? pick_gap() : 0;
      end
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               $display("%0t: unexpected transfer scl %b sda_low %b busy %b done %b rx %0h err %b",
                        $time, rsp_scl_level, rsp_sda_drive_low, rsp_busy_res, rsp_done_res,
                        rsp_rx_byte, rsp_ack_error);
               faults++;
            end else begin
               want = expected_pins.pop_front();
               compare_field("scl_level", 8'(want.scl), 8'(rsp_scl_level));
               compare_field("sda_drive_low", 8'(want.sda_low), 8'(rsp_sda_drive_low));
               compare_field("busy_res", 8'(want.busy), 8'(rsp_busy_res));
               compare_field("done_res", 8'(want.done), 8'(rsp_done_res));
               compare_field("rx_byte", want.rx, rsp_rx_byte);
               compare_field("ack_error", 8'(want.err), 8'(rsp_ack_error));
            end
         end
         if (req_valid && !req_stall) begin
            taken.mode = req_mode;
            taken.tx_byte = req_tx_byte;
            taken.send_ack = req_send_ack;
            taken.sda_level = req_sda_level;
            seq_tick(tick_model, cfg, taken, got);
            expected_pins.push_back(got);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("i2c_master_bit_sequencer verification failed");
      $finish;
   end

   initial begin
      cfg.delay_ticks = DELAY_TICKS_RESET;
      cfg.ack_limit = ACK_LIMIT_RESET;
      tick_model = seq_idle();
      plan_state = seq_idle();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // directed pass at the reset settings
      queue_command(MODE_NONE, 8'h00, 1'b0, 0, 1'b0);
      queue_command(MODE_UNUSED_A, 8'hFF, 1'b1, 0, 1'b0);
      queue_command(MODE_UNUSED_B, 8'h00, 1'b0, 0, 1'b0);
      queue_command(MODE_START, 8'hFF, 1'b1, 0, 1'b0);
      queue_command(MODE_WRITE, 8'h00, 1'b0, 0, 1'b0);
      queue_command(MODE_WRITE, 8'hFF, 1'b1, 0, 1'b1);
      queue_command(MODE_WRITE, 8'h5A, 1'b0, 0, 1'b0);
      queue_command(MODE_WAIT, 8'h00, 1'b0, 0, 1'b0);
      queue_command(MODE_WAIT, 8'hFF, 1'b1, 3, 1'b1);
      queue_command(MODE_READ, 8'h00, 1'b1, 0, 1'b0);
      queue_command(MODE_READ, 8'hFF, 1'b0, 0, 1'b1);
      queue_command(MODE_WAIT, 8'h00, 1'b0, 1000, 1'b0);
      queue_command(MODE_STOP, 8'hA5, 1'b1, 0, 1'b0);
      wait_drained();

      // zero delay counts as one tick; ack limit of 1
      write_csr(CSR_DELAY_TICKS, 16'h0000);
      write_csr(CSR_ACK_LIMIT, {8'($urandom), 8'd1});
      queue_command(MODE_WAIT, 8'h00, 1'b0, 1, 1'b0);
      queue_command(MODE_WAIT, 8'h00, 1'b0, 2, 1'b0);
      queue_random(30);
      wait_drained();

      write_csr(CSR_DELAY_TICKS, 16'h0001);
      write_csr(CSR_ACK_LIMIT, {8'($urandom), 8'd255});
      queue_command(MODE_WAIT, 8'h00, 1'b0, 256, 1'b0);
      queue_random(30);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         gaps_on = (p != 2);
         write_csr(CSR_DELAY_TICKS, 16'($urandom_range(1, 6)));
         write_csr(CSR_ACK_LIMIT, {8'($urandom), ($urandom_range(0, 3) == 0) ?
                                   8'($urandom_range(1, 255)) : 8'($urandom_range(1, 12))});
         queue_random(20);
         wait_drained();
      end

      // long delay: one start sequence at full rate
      gaps_on = 1'b0;
      write_csr(CSR_DELAY_TICKS, 16'h0080);
      write_csr(CSR_ACK_LIMIT, 16'h0003);
      queue_command(MODE_START, 8'h00, 1'b0, 0, 1'b0);
      wait_drained();

      gaps_on = 1'b1;
      write_csr(CSR_DELAY_TICKS, 16'h0002);
      write_csr(CSR_ACK_LIMIT, 16'h0004);
      queue_random(30);
      wait_drained();

      if (faults == 0) begin
         $display("i2c_master_bit_sequencer verification clean");
      end else begin
         $display("i2c_master_bit_sequencer verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/i2cs_pkg.sv
sv/i2cs_step.sv
sv/i2c_master_bit_sequencer.sv
test/i2c_master_bit_sequencer_test.sv
